FILE: sv/gfca_pkg.sv
`default_nettype none
package gfca_pkg;

  localparam int ADDR_W  = 15;
  localparam int COUNT_W = 12;
  localparam int CFG_W   = 5;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 2;

  localparam logic [KIND_W-1:0] KIND_FORMAT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;
  localparam logic [CFG_W-1:0]   GC_RESET  = 5'd16;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] cluster_address;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ADDR_W-1:0]  granted_address;
    logic [COUNT_W-1:0] free_count;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/gfca_stack_mem.sv
`default_nettype none
module gfca_stack_mem #(
  parameter int AW = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [gfca_pkg::ADDR_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [gfca_pkg::ADDR_W-1:0] rdata_o
);
  import gfca_pkg::*;

  logic [ADDR_W-1:0] mem_q [2**AW];
  logic [ADDR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: sv/grouped_free_cluster_allocator.sv
// Channel   | Direction | Handshake                      | Beat
// ----------+-----------+--------------------------------+---------------------------------
// command   | in        | start & !busy                  | req_i (kind, cluster_address)
// result    | out       | done_o, one cycle, no backpres. | res_o (status, granted, free)
// config    | in        | cfg_we_i                       | cfg_wdata_i (group_count)
//
// Sequence: format, release and unknown kinds pass ST_EXEC and show done_o from
// the done register; a successful allocate also waits in ST_POP for the stack memory read.
// A new command can be accepted in the cycle that done_o is shown.
// Reset: asynchronous, clears all group counters, links and the free total; no
// clearing pass over the stack memory is needed, format marks slots lazily.
// Stalls: none, the receiver always takes the result beat.
`default_nettype none
module grouped_free_cluster_allocator #(
  parameter int MAX_GROUPS         = 16,
  parameter int CLUSTERS_PER_GROUP = 256,
  parameter int BLOCKS_PER_CLUSTER = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  input  wire gfca_pkg::item_t            req_i,
  output logic                            busy,
  output logic                            done_o,
  output gfca_pkg::result_t               res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [gfca_pkg::CFG_W-1:0] cfg_wdata_i
);
  import gfca_pkg::*;

  // group index, stack slot and memory address widths
  localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int NW  = GW + 1;
  localparam int SW  = $clog2(CLUSTERS_PER_GROUP);
  localparam int MAW = GW + SW;

  // group of a block address: multiply by a rounded-up reciprocal of the
  // group span, exact for every 15-bit address
  localparam longint SPAN  = longint'(CLUSTERS_PER_GROUP) * BLOCKS_PER_CLUSTER;
  localparam int     LSPAN = $clog2(SPAN);
  localparam int     SHIFT = ADDR_W + LSPAN;
  localparam longint RECIP = ((longint'(1) << SHIFT) + SPAN - 1) / SPAN;
  localparam int     MW    = $clog2(RECIP + 1);
  localparam int     PW    = ADDR_W + MW;
  localparam int     QW    = PW - SHIFT;
  localparam int     CW    = (QW > NW) ? QW : NW;

  // width for the format total and for the lazily computed fill address
  localparam int FTW = (NW + SW > COUNT_W) ? NW + SW : COUNT_W + 1;
  localparam int CIW = GW + SW + 1;
  localparam int AFW = (CIW + 7 > ADDR_W) ? CIW + 7 : ADDR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP
  } state_e;

  state_e              state_q, state_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic [QW-1:0]       quo_q, quo_d;
  logic [CFG_W-1:0]    gc_q, gc_d;

  // per-group stack depth, formatted low-water mark and FIFO link
  logic [SW-1:0]       cnt_q [MAX_GROUPS];
  logic [SW-1:0]       cnt_d [MAX_GROUPS];
  logic [SW-1:0]       fill_q [MAX_GROUPS];
  logic [SW-1:0]       fill_d [MAX_GROUPS];
  logic [GW-1:0]       link_q [MAX_GROUPS];
  logic [GW-1:0]       link_d [MAX_GROUPS];
  logic                link_vld_q [MAX_GROUPS];
  logic                link_vld_d [MAX_GROUPS];

  logic [GW-1:0]       head_q, head_d, tail_q, tail_d;
  logic                head_vld_q, head_vld_d, tail_vld_q, tail_vld_d;
  logic [COUNT_W-1:0]  free_q, free_d;

  logic [GW-1:0]       pop_grp_q, pop_grp_d;
  logic [SW-1:0]       pop_slot_q, pop_slot_d;
  logic                pop_fill_q, pop_fill_d;

  logic                done_q, done_d;
  result_t             res_q, res_d;

  logic [NW-1:0]       n_eff;
  logic [PW-1:0]       prod;
  logic [CW-1:0]       quo_ext;
  logic [GW-1:0]       rel_grp, sel_grp;
  logic                rel_oor;
  logic [SW-1:0]       sel_cnt, pop_slot;
  logic [FTW-1:0]      fmt_total;
  logic [CIW-1:0]      fill_cl;
  logic [AFW-1:0]      fill_addr;

  logic                mem_we, mem_re;
  logic [MAW-1:0]      mem_waddr, mem_raddr;
  logic [ADDR_W-1:0]   mem_rdata;

  gfca_stack_mem #(
    .AW (MAW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (addr_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // clamp the configured group count to the storage that exists
  assign n_eff = (int'(gc_q) > MAX_GROUPS) ? NW'(MAX_GROUPS) : NW'(gc_q);

  assign prod    = PW'(req_i.cluster_address) * PW'(RECIP);
  assign quo_ext = CW'(quo_q);
  assign rel_grp = GW'(quo_ext);
  assign rel_oor = (quo_ext >= CW'(n_eff));

  // one counter read port: allocate looks at the head, release at its group
  assign sel_grp  = (kind_q == KIND_ALLOC) ? head_q : rel_grp;
  assign sel_cnt  = cnt_q[sel_grp];
  assign pop_slot = sel_cnt - SW'(1);

  assign fmt_total = FTW'(n_eff) * FTW'(CLUSTERS_PER_GROUP - 1) - FTW'(1);

  // a slot below the low-water mark still holds its formatted address:
  // group base plus cluster (C-1-slot), scaled to blocks
  assign fill_cl   = CIW'(pop_grp_q) * CIW'(CLUSTERS_PER_GROUP)
                   + CIW'(CLUSTERS_PER_GROUP - 1) - CIW'(pop_slot_q);
  assign fill_addr = AFW'(fill_cl) * AFW'(BLOCKS_PER_CLUSTER);

  assign gc_d = cfg_we_i ? cfg_wdata_i : gc_q;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    addr_d     = addr_q;
    quo_d      = quo_q;
    cnt_d      = cnt_q;
    fill_d     = fill_q;
    link_d     = link_q;
    link_vld_d = link_vld_q;
    head_d     = head_q;
    head_vld_d = head_vld_q;
    tail_d     = tail_q;
    tail_vld_d = tail_vld_q;
    free_d     = free_q;
    pop_grp_d  = pop_grp_q;
    pop_slot_d = pop_slot_q;
    pop_fill_d = pop_fill_q;
    done_d     = 1'b0;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = {rel_grp, sel_cnt};
    mem_raddr  = {head_q, pop_slot};

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
          kind_d  = req_i.kind;
          addr_d  = req_i.cluster_address;
          quo_d   = prod[PW-1:SHIFT];
        end
      end

      ST_EXEC: begin
        state_d               = ST_IDLE;
        done_d                = 1'b1;
        res_d.status          = STAT_OK;
        res_d.granted_address = '0;

        unique case (kind_q)
          KIND_FORMAT: begin
            // rebuild every group at once; stack slots are filled lazily
            for (int g = 0; g < MAX_GROUPS; g++) begin
              if (g < int'(n_eff)) begin
                cnt_d[g]  = (g == 0) ? SW'(CLUSTERS_PER_GROUP - 2)
                                     : SW'(CLUSTERS_PER_GROUP - 1);
                fill_d[g] = cnt_d[g];
              end else begin
                cnt_d[g]  = '0;
                fill_d[g] = '0;
              end
              link_d[g]     = GW'(g + 1);
              link_vld_d[g] = (g + 1 < int'(n_eff));
            end
            head_d = '0;
            tail_d = GW'(n_eff - NW'(1));
            if (n_eff == '0) begin
              head_vld_d   = 1'b0;
              tail_vld_d   = 1'b0;
              free_d       = '0;
              res_d.status = STAT_NOFREE;
            end else begin
              head_vld_d = 1'b1;
              tail_vld_d = 1'b1;
              free_d     = (fmt_total > FTW'(COUNT_MAX)) ? COUNT_MAX
                                                         : fmt_total[COUNT_W-1:0];
            end
          end

          KIND_ALLOC: begin
            if (free_q == '0 || !head_vld_q || sel_cnt == '0) begin
              res_d.status = STAT_NOFREE;
            end else begin
              // pop: read the top slot, finish the beat after the read returns
              cnt_d[head_q] = pop_slot;
              mem_re        = 1'b1;
              pop_grp_d     = head_q;
              pop_slot_d    = pop_slot;
              pop_fill_d    = (pop_slot < fill_q[head_q]);
              if (pop_slot == '0) begin
                head_d     = link_q[head_q];
                head_vld_d = link_vld_q[head_q];
                if (!link_vld_q[head_q]) begin
                  tail_vld_d = 1'b0;
                end
              end
              free_d  = free_q - COUNT_W'(1);
              state_d = ST_POP;
              done_d  = 1'b0;
            end
          end

          KIND_RELEASE: begin
            if (rel_oor) begin
              res_d.status = STAT_RANGE;
            end else if (sel_cnt >= SW'(CLUSTERS_PER_GROUP - 1)) begin
              res_d.status = STAT_FULL;
            end else begin
              // push the address and lower the low-water mark over it
              mem_we         = 1'b1;
              cnt_d[rel_grp] = sel_cnt + SW'(1);
              if (sel_cnt < fill_q[rel_grp]) begin
                fill_d[rel_grp] = sel_cnt;
              end
              if (sel_cnt == '0) begin
                // group had run empty: append it at the tail
                link_vld_d[rel_grp] = 1'b0;
                if (!head_vld_q || !tail_vld_q) begin
                  head_d     = rel_grp;
                  head_vld_d = 1'b1;
                end else begin
                  link_d[tail_q]     = rel_grp;
                  link_vld_d[tail_q] = 1'b1;
                end
                tail_d     = rel_grp;
                tail_vld_d = 1'b1;
              end
              if (free_q != COUNT_MAX) begin
                free_d = free_q + COUNT_W'(1);
              end
            end
          end

          default: begin
            // unused kind: report state unchanged
          end
        endcase

        res_d.free_count = free_d;
      end

      ST_POP: begin
        state_d               = ST_IDLE;
        done_d                = 1'b1;
        res_d.status          = STAT_OK;
        res_d.granted_address = pop_fill_q ? fill_addr[ADDR_W-1:0] : mem_rdata;
        res_d.free_count      = free_q;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      gc_q       <= GC_RESET;
      head_q     <= '0;
      head_vld_q <= 1'b0;
      tail_q     <= '0;
      tail_vld_q <= 1'b0;
      free_q     <= '0;
      done_q     <= 1'b0;
      for (int g = 0; g < MAX_GROUPS; g++) begin
        cnt_q[g]      <= '0;
        fill_q[g]     <= '0;
        link_q[g]     <= '0;
        link_vld_q[g] <= 1'b0;
      end
    end else begin
      state_q    <= state_d;
      gc_q       <= gc_d;
      head_q     <= head_d;
      head_vld_q <= head_vld_d;
      tail_q     <= tail_d;
      tail_vld_q <= tail_vld_d;
      free_q     <= free_d;
      done_q     <= done_d;
      cnt_q      <= cnt_d;
      fill_q     <= fill_d;
      link_q     <= link_d;
      link_vld_q <= link_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    addr_q     <= addr_d;
    quo_q      <= quo_d;
    pop_grp_q  <= pop_grp_d;
    pop_slot_q <= pop_slot_d;
    pop_fill_q <= pop_fill_d;
    res_q      <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

FILE: sv/gfca_checker.sv
`default_nettype none
module gfca_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire gfca_pkg::item_t            req_i,
  input wire logic                       busy,
  input wire logic                       done_o,
  input wire gfca_pkg::result_t          res_o,
  input wire logic                       cfg_we_i,
  input wire logic [gfca_pkg::CFG_W-1:0] cfg_wdata_i
);
  import gfca_pkg::*;

  // an accepted command occupies the block in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // after ST_EXEC the beat is out or the pop is still waiting on memory
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 (done_o || busy))
    else $error("result beat missing after command");

  // the pop cycle always ends in a result beat
  a_pop_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && $past(busy)) |=> done_o)
    else $error("allocate did not finish after memory read");

  // a result beat is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // only a good allocate grants an address
  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.status != STAT_OK) |-> (res_o.granted_address == '0))
    else $error("address granted on failed command");

endmodule

bind grouped_free_cluster_allocator gfca_checker u_gfca_checker (.*);
`default_nettype wire

FILE: tb/tb_grouped_free_cluster_allocator.sv
`default_nettype none
module tb_grouped_free_cluster_allocator;
  import gfca_pkg::*;

  // Geometry matches the default parameters of the block.
  localparam int GROUPS       = 16;
  localparam int CLUSTERS     = 256;
  localparam int BLOCKS       = 8;
  localparam int STACK_CAP    = CLUSTERS - 1;
  // Allow a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 880;
  // Settle a little longer than the longest command, a successful allocate, takes.
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;

  // Kind 3 has no operation behind it; the block answers it without change.
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;
  localparam logic [4:0]        GROUP_NONE = 5'h1F;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 done_o;
  logic                 cfg_we_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  item_t                req_i;
  result_t              res_o;

  grouped_free_cluster_allocator #(
    .MAX_GROUPS        (GROUPS),
    .CLUSTERS_PER_GROUP(CLUSTERS),
    .BLOCKS_PER_CLUSTER(BLOCKS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Predicted allocator state: per-group free stacks, the FIFO of groups that
  // still hold free clusters, and the running free total.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  slot_addr   [GROUPS*CLUSTERS];
  logic [7:0]         stack_depth [GROUPS];
  logic [4:0]         next_group  [GROUPS];
  logic [4:0]         head_group;
  logic [4:0]         tail_group;
  logic [COUNT_W-1:0] free_clusters;
  logic [CFG_W-1:0]   group_setting;

  result_t            due_results[$];    // one per accepted command, oldest first
  logic [ADDR_W-1:0]  held_clusters[$];  // granted and not yet handed back
  int                 mismatch_count = 0;
  int                 cycle_count    = 0;
  int                 random_sent    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Clamp the register to the number of groups that exist.
  function automatic logic [4:0] groups_in_use();
    return (group_setting > GROUPS) ? 5'(GROUPS) : group_setting;
  endfunction

  function automatic void clear_lists();
    for (int gi = 0; gi < GROUPS; gi++) begin
      stack_depth[gi] = '0;
      next_group[gi]  = GROUP_NONE;
    end
    head_group    = GROUP_NONE;
    tail_group    = GROUP_NONE;
    free_clusters = '0;
  endfunction

  // Apply one command to the predicted state and return the result it owes.
  function automatic result_t predict_cluster_op(item_t cmd);
    result_t    r;
    logic [4:0] n;
    logic [4:0] g;
    logic [7:0] d;
    int         total;
    n                 = groups_in_use();
    r.status          = STAT_OK;
    r.granted_address = '0;
    case (cmd.kind)
      KIND_FORMAT: begin
        clear_lists();
        held_clusters.delete();
        if (n == 0) begin
          r.status = STAT_NOFREE;
        end else begin
          total = 0;
          // Stack bottom is the highest cluster, top the lowest; group 0 keeps
          // its header and first user cluster reserved.
          for (int gi = 0; gi < n; gi++) begin
            d = (gi == 0) ? 8'(CLUSTERS - 2) : 8'(STACK_CAP);
            for (int s = 0; s < d; s++)
              slot_addr[gi*CLUSTERS + s] =
                ADDR_W'(gi*CLUSTERS*BLOCKS + (CLUSTERS - 1 - s)*BLOCKS);
            stack_depth[gi] = d;
            next_group[gi]  = (gi + 1 < n) ? 5'(gi + 1) : GROUP_NONE;
            total += d;
          end
          head_group    = '0;
          tail_group    = n - 5'd1;
          free_clusters = COUNT_W'(total);
        end
      end
      KIND_ALLOC: begin
        if (free_clusters == 0 || head_group >= GROUPS || stack_depth[head_group] == 0) begin
          r.status = STAT_NOFREE;
        end else begin
          g = head_group;
          d = stack_depth[g] - 8'd1;
          stack_depth[g]    = d;
          r.granted_address = slot_addr[g*CLUSTERS + d];
          // Unlink the head group once its stack runs dry.
          if (d == 0) begin
            head_group = next_group[g];
            if (head_group == GROUP_NONE) tail_group = GROUP_NONE;
          end
          free_clusters = free_clusters - COUNT_W'(1);
          held_clusters.push_back(r.granted_address);
        end
      end
      KIND_RELEASE: begin
        g = 5'(cmd.cluster_address / (CLUSTERS*BLOCKS));
        if (g >= n) begin
          r.status = STAT_RANGE;
        end else if (stack_depth[g] >= STACK_CAP) begin
          r.status = STAT_FULL;
        end else begin
          d = stack_depth[g];
          slot_addr[g*CLUSTERS + d] = cmd.cluster_address;
          stack_depth[g] = d + 8'd1;
          // A group that was empty rejoins the list at the tail.
          if (d == 0) begin
            next_group[g] = GROUP_NONE;
            if (head_group == GROUP_NONE || tail_group >= GROUPS) head_group = g;
            else next_group[tail_group] = g;
            tail_group = g;
          end
          if (free_clusters != COUNT_MAX) free_clusters = free_clusters + COUNT_W'(1);
        end
      end
      default: ;
    endcase
    r.free_count = free_clusters;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: check the result beat against the oldest prediction, then track
  // register writes and predict every command taken at this edge. One process
  // does all three so their order within the edge is fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (due_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result beat: status %0d granted %h free %0d",
                     res_o.status, res_o.granted_address, res_o.free_count);
        end else begin
          want = due_results.pop_front();
          if (res_o.status !== want.status ||
              res_o.granted_address !== want.granted_address ||
              res_o.free_count !== want.free_count) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result mismatch (exp/act): status %0d/%0d granted %h/%h free %0d/%0d",
                       want.status, res_o.status, want.granted_address,
                       res_o.granted_address, want.free_count, res_o.free_count);
          end
        end
      end
      if (cfg_we_i) group_setting = cfg_wdata_i;
      if (start && !busy) due_results.push_back(predict_cluster_op(req_i));
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. Inputs change on the falling edge only. send_cmd leaves start
  // high so the next beat can follow back to back; every sequence ends with
  // pause or settle, which drop it.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [KIND_W-1:0] op, input logic [ADDR_W-1:0] addr);
    logic taken;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= '{kind: op, cluster_address: addr};
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
    end
  endtask

  task automatic pause(input int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Drop start and hold until every predicted result has come back.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Call only once settled.
  task automatic write_group_count(input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Before any format every stack is empty: nothing to allocate, releases
  // build the group list from scratch.
  task automatic test_empty_after_reset();
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_NONE, 15'h5555);
    send_cmd(KIND_RELEASE, 15'h7FFF);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_RELEASE, '0);
    send_cmd(KIND_ALLOC, 15'h2AAA);
    settle();
  endtask

  // Oversized group count clamps to all groups; pops come out lowest first and
  // a release is handed straight back (LIFO), unaligned or not. Zero groups
  // formats to nothing and rejects every release.
  task automatic test_format_and_lifo();
    write_group_count(5'd31);
    send_cmd(KIND_FORMAT, '0);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_RELEASE, 15'h7FFF);
    send_cmd(KIND_RELEASE, 15'd1);
    send_cmd(KIND_ALLOC, '0);
    settle();
    write_group_count(5'd0);
    send_cmd(KIND_FORMAT, '0);
    send_cmd(KIND_ALLOC, '0);
    send_cmd(KIND_RELEASE, '0);
    settle();
  endtask

  // Fresh group 1 is full; group 0 has one spare slot; groups past the count
  // are out of range.
  task automatic test_full_and_range();
    write_group_count(5'd2);
    send_cmd(KIND_FORMAT, '0);
    send_cmd(KIND_RELEASE, 15'h0800);
    send_cmd(KIND_RELEASE, 15'h0008);
    send_cmd(KIND_RELEASE, 15'h0010);
    send_cmd(KIND_RELEASE, 15'h1000);
    send_cmd(KIND_NONE, '0);
    settle();
    write_group_count(5'd1);
  endtask

  // ---------------------------------------------------------------------------
  // Random phases
  // ---------------------------------------------------------------------------

  // Favor the extremes of the register.
  function automatic logic [CFG_W-1:0] pick_group_count();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return 5'd16;
    if (roll < 32) return 5'd31;
    if (roll < 42) return 5'd1;
    if (roll < 46) return 5'd0;
    return 5'($urandom_range(1, 31));
  endfunction

  // Mostly hand back granted clusters or legal addresses; a few wild ones.
  function automatic logic [ADDR_W-1:0] pick_release_address();
    logic [ADDR_W-1:0] a;
    logic [4:0]        n;
    int                idx;
    int                roll;
    n    = groups_in_use();
    roll = $urandom_range(0, 99);
    if (roll < 55 && held_clusters.size() != 0) begin
      idx = $urandom_range(0, held_clusters.size() - 1);
      a   = held_clusters[idx];
      held_clusters.delete(idx);
    end else if (roll < 92 && n != 0) begin
      a = ADDR_W'($urandom);
      a[ADDR_W-1 -: 4] = 4'($urandom_range(0, n - 1));
      if (roll < 85) a[2:0] = '0;
    end else begin
      a = ADDR_W'($urandom);
    end
    return a;
  endfunction

  // mode 0: drain one group to empty and beyond; mode 1: start from empty
  // stacks and churn; mode 2: churn from a fresh format.
  task automatic run_phase(input int mode, input int len);
    int alloc_pct;
    int release_pct;
    int gap_pct;
    int roll;
    logic [KIND_W-1:0] op;
    logic [ADDR_W-1:0] addr;
    case (mode)
      0: begin
        write_group_count(5'd1);
        alloc_pct   = 80;
        release_pct = 95;
      end
      1: begin
        write_group_count(5'd0);
        send_cmd(KIND_FORMAT, ADDR_W'($urandom));
        settle();
        write_group_count(pick_group_count());
        alloc_pct   = 45;
        release_pct = 95;
      end
      default: begin
        write_group_count(pick_group_count());
        alloc_pct   = 40;
        release_pct = 92;
      end
    endcase
    if (mode != 1) send_cmd(KIND_FORMAT, ADDR_W'($urandom));
    case ($urandom_range(0, 2))
      0:       gap_pct = 0;
      1:       gap_pct = 8;
      default: gap_pct = 30;
    endcase
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      addr = ADDR_W'($urandom);
      if (roll < alloc_pct) begin
        op = KIND_ALLOC;
      end else if (roll < release_pct) begin
        op   = KIND_RELEASE;
        addr = pick_release_address();
      end else if (roll < release_pct + 2) begin
        op = KIND_FORMAT;
      end else if (roll < release_pct + 5) begin
        op = KIND_NONE;
      end else begin
        op = KIND_RELEASE;  // address left wild
      end
      send_cmd(op, addr);
      if (op != KIND_NONE) random_sent++;
      // Keep the tail of the run free of gaps.
      if (random_sent < RANDOM_ITEMS*4/5 && $urandom_range(0, 99) < gap_pct)
        pause($urandom_range(1, 18));
    end
    settle();
  endtask

  task automatic test_random_phases();
    int phase_no;
    int mode;
    int len;
    phase_no = 0;
    while (random_sent < RANDOM_ITEMS) begin
      // Open with a drain and an empty-start phase, then mix.
      if (phase_no == 0) mode = 0;
      else if (phase_no == 1) mode = 1;
      else mode = $urandom_range(0, 2);
      len = (mode == 0) ? 300 : $urandom_range(60, 200);
      // Stop close to the item budget.
      if (len > RANDOM_ITEMS - random_sent) len = RANDOM_ITEMS - random_sent;
      run_phase(mode, len);
      phase_no++;
    end
  endtask

  initial begin
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    clear_lists();
    group_setting = GC_RESET;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_after_reset();
    test_format_and_lifo();
    test_full_and_range();
    test_random_phases();

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
